[rtl/sparse_row_statistics_defines.svh]
// assertion macros for the sparse row statistics block
// used by the rtl files that carry assertions; needs nothing else
`ifndef SPARSE_ROW_STATISTICS_DEFINES_SVH
`define SPARSE_ROW_STATISTICS_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SRS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define SRS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

[rtl/srs_pkg.sv]
// shared widths, limits, types and codes of the sparse row statistics block
// depends on nothing; the other rtl files, the defines header apart, refer to it by scoped names
package srs_pkg;

   // entry count limit and fixed point format
   localparam int MAX_ROW_ENTRIES = 4096;
   localparam int FRAC_BITS       = 16;

   // field widths
   localparam int CNT_W  = $clog2(MAX_ROW_ENTRIES + 1);
   localparam int VAL_W  = 32;
   localparam int THR_W  = 31;
   localparam int CAVG_W = 28;
   localparam int SUM_W  = 48;
   localparam int ABS_W  = 47;
   localparam int NZ_W   = 36;
   localparam int TOT_W  = 64;
   localparam int ACC_W  = 63;
   localparam int CSR_W  = 48;
   localparam int CSR_IDX_W = 2;

   // deviation and square datapath widths
   localparam int DEV_W = (SUM_W + 1 > CNT_W + FRAC_BITS + 1) ?
                          SUM_W + 1 : CNT_W + FRAC_BITS + 1;
   localparam int MAG_W = DEV_W;
   localparam int LO_W  = (MAG_W + 1) / 2;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int SQ_W  = 2 * MAG_W;

   // back pipeline depth: deviation stage plus the three stages of the square
   localparam int BACK_STAGES = 4;

   // row queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // limits and initial values
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
   localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};
   localparam logic [ABS_W-1:0] ABS_MAX = {ABS_W{1'b1}};
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [NZ_W-1:0]  NZ_MAX  = {NZ_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ROW_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_LOW_INIT = {CNT_W{1'b1}};

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_COUNT_AVG = 2'd1,
      CSR_SUM_AVG   = 2'd2,
      CSR_ABS_AVG   = 2'd3
   } csr_index_type;

   // one finished row as handed from front to back
   typedef struct packed {
      logic                    mlast;
      logic [NZ_W-1:0]         nonzero;
      logic [CNT_W-1:0]        cnt;
      logic signed [SUM_W-1:0] ssum;
      logic [ABS_W-1:0]        asum;
   } row_rec_type;

endpackage

[rtl/srs_req_if.sv]
// input channel of the sparse row statistics block: one matrix entry a word
// depends on srs_pkg for field widths
interface srs_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [srs_pkg::VAL_W-1:0] value;
   logic                            has_value;
   logic                            row_last;
   logic                            matrix_last;

   modport source (output valid, value, has_value, row_last, matrix_last, input ready);
   modport sink   (input valid, value, has_value, row_last, matrix_last, output ready);
endinterface

[rtl/srs_rsp_if.sv]
// result channel of the sparse row statistics block: one word per matrix
// depends on srs_pkg for field widths
interface srs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [srs_pkg::NZ_W-1:0]         nonzero_count;
   logic [srs_pkg::CNT_W-1:0]        count_min;
   logic [srs_pkg::CNT_W-1:0]        count_max;
   logic signed [srs_pkg::SUM_W-1:0] sum_min;
   logic signed [srs_pkg::SUM_W-1:0] sum_max;
   logic signed [srs_pkg::TOT_W-1:0] sum_total;
   logic [srs_pkg::ABS_W-1:0]        abs_min;
   logic [srs_pkg::ABS_W-1:0]        abs_max;
   logic [srs_pkg::ACC_W-1:0]        abs_total;
   logic [srs_pkg::ACC_W-1:0]        count_sq_dev;
   logic [srs_pkg::ACC_W-1:0]        sum_sq_dev;
   logic [srs_pkg::ACC_W-1:0]        abs_sq_dev;

   modport source (output valid, nonzero_count, count_min, count_max, sum_min, sum_max,
                   sum_total, abs_min, abs_max, abs_total, count_sq_dev, sum_sq_dev,
                   abs_sq_dev, input ready);
   modport sink   (input valid, nonzero_count, count_min, count_max, sum_min, sum_max,
                   sum_total, abs_min, abs_max, abs_total, count_sq_dev, sum_sq_dev,
                   abs_sq_dev, output ready);
endinterface

[rtl/srs_fifo.sv]
// short queue of finished rows between the front and the back
// depends on srs_pkg and sparse_row_statistics_defines.svh
`include "sparse_row_statistics_defines.svh"

module srs_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srs_pkg::row_rec_type push_rec,
   input  logic                 pop,
   output srs_pkg::row_rec_type pop_rec,
   output logic                 empty,
   output logic                 full
);

   srs_pkg::row_rec_type             mem_ff [srs_pkg::FIFO_DEPTH];
   logic [srs_pkg::FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [srs_pkg::FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [srs_pkg::FIFO_AW:0]        fill_ff, fill_in;

   // status and read side
   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == (srs_pkg::FIFO_AW+1)'(srs_pkg::FIFO_DEPTH));
   assign pop_rec = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `SRS_ASSERT_NOW(a_fifo_fill_bound, clock, reset, 1'b1,
      fill_ff <= (srs_pkg::FIFO_AW+1)'(srs_pkg::FIFO_DEPTH), "row queue overfilled")
   `SRS_ASSERT_NOW(a_fifo_no_underflow, clock, reset, pop, fill_ff != '0,
      "row queue read while empty")
   `SRS_ASSERT_NOW(a_fifo_no_overflow, clock, reset, push, !full,
      "row queue written while full")

endmodule

[rtl/srs_front.sv]
// front part: takes entry words and builds per-row count, sums and nonzero total
// depends on srs_pkg, srs_req_if and sparse_row_statistics_defines.svh
`include "sparse_row_statistics_defines.svh"

module srs_front (
   input  logic                       clock,
   input  logic                       reset,
   srs_req_if.sink                    req_bus,
   input  logic [srs_pkg::THR_W-1:0]  threshold,
   input  logic                       fifo_full,
   output logic                       push,
   output srs_pkg::row_rec_type       push_rec
);

   logic [srs_pkg::CNT_W-1:0]        row_cnt_ff, row_cnt_in;
   logic signed [srs_pkg::SUM_W-1:0] row_ssum_ff, row_ssum_in;
   logic [srs_pkg::ABS_W-1:0]        row_asum_ff, row_asum_in;
   logic [srs_pkg::NZ_W-1:0]         nz_ff, nz_in;
   logic                             accept;
   logic [srs_pkg::VAL_W-1:0]        mag;
   logic signed [srs_pkg::SUM_W:0]   ssum_wide;
   logic [srs_pkg::ABS_W:0]          asum_wide;
   srs_pkg::row_rec_type             rec;

   assign req_bus.ready = !fifo_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept && req_bus.row_last;
   assign push_rec      = rec;

   // row accumulation including the current word
   always_comb begin
      mag = req_bus.value[srs_pkg::VAL_W-1] ? srs_pkg::VAL_W'(-req_bus.value)
                                             : srs_pkg::VAL_W'(req_bus.value);
      ssum_wide = (srs_pkg::SUM_W+1)'(row_ssum_ff) + (srs_pkg::SUM_W+1)'(req_bus.value);
      asum_wide = (srs_pkg::ABS_W+1)'(row_asum_ff) + (srs_pkg::ABS_W+1)'(mag);
      rec.mlast   = req_bus.matrix_last;
      rec.nonzero = nz_ff;
      rec.cnt     = row_cnt_ff;
      rec.ssum    = row_ssum_ff;
      rec.asum    = row_asum_ff;
      if (req_bus.has_value) begin
         if (mag > srs_pkg::VAL_W'(threshold) && nz_ff != srs_pkg::NZ_MAX) begin
            rec.nonzero = nz_ff + 1'b1;
         end
         if (row_cnt_ff < srs_pkg::CNT_LIMIT) begin
            rec.cnt = row_cnt_ff + 1'b1;
         end
         if (ssum_wide[srs_pkg::SUM_W] != ssum_wide[srs_pkg::SUM_W-1]) begin
            rec.ssum = ssum_wide[srs_pkg::SUM_W] ? srs_pkg::SUM_MIN : srs_pkg::SUM_MAX;
         end else begin
            rec.ssum = ssum_wide[srs_pkg::SUM_W-1:0];
         end
         rec.asum = asum_wide[srs_pkg::ABS_W] ? srs_pkg::ABS_MAX
                                              : asum_wide[srs_pkg::ABS_W-1:0];
      end
   end

   // next state: row end clears the row, matrix end clears the nonzero total
   always_comb begin
      row_cnt_in  = row_cnt_ff;
      row_ssum_in = row_ssum_ff;
      row_asum_in = row_asum_ff;
      nz_in       = nz_ff;
      if (accept) begin
         row_cnt_in  = req_bus.row_last ? '0 : rec.cnt;
         row_ssum_in = req_bus.row_last ? '0 : rec.ssum;
         row_asum_in = req_bus.row_last ? '0 : rec.asum;
         nz_in       = (req_bus.row_last && req_bus.matrix_last) ? '0 : rec.nonzero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff  <= '0;
         row_ssum_ff <= '0;
         row_asum_ff <= '0;
         nz_ff       <= '0;
      end else begin
         row_cnt_ff  <= row_cnt_in;
         row_ssum_ff <= row_ssum_in;
         row_asum_ff <= row_asum_in;
         nz_ff       <= nz_in;
      end
   end

   `SRS_ASSERT_NEXT(a_front_row_cleared, clock, reset, push,
      row_cnt_ff == '0 && row_ssum_ff == '0 && row_asum_ff == '0,
      "row accumulators not cleared after row end")

endmodule

[rtl/srs_square.sv]
// pipelined scaled square: |d|^2 >> FRAC_BITS, saturated, three stages
// depends on srs_pkg
module srs_square (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [srs_pkg::DEV_W-1:0] diff,
   output logic [srs_pkg::ACC_W-1:0]        square
);

   logic [srs_pkg::MAG_W-1:0]             mag_ff, mag_in;
   logic [2*srs_pkg::HI_W-1:0]            hh_ff;
   logic [srs_pkg::HI_W+srs_pkg::LO_W-1:0] hl_ff;
   logic [2*srs_pkg::LO_W-1:0]            ll_ff;
   logic [srs_pkg::SQ_W-1:0]              full_sq;
   logic [srs_pkg::SQ_W-1:0]              scaled;
   logic [srs_pkg::ACC_W-1:0]             sq_ff, sq_in;
   logic [srs_pkg::HI_W-1:0]              mag_hi;
   logic [srs_pkg::LO_W-1:0]              mag_lo;

   assign mag_in = diff[srs_pkg::DEV_W-1] ? srs_pkg::MAG_W'(-diff)
                                          : srs_pkg::MAG_W'(diff);
   assign mag_hi = mag_ff[srs_pkg::MAG_W-1:srs_pkg::LO_W];
   assign mag_lo = mag_ff[srs_pkg::LO_W-1:0];

   // hi*hi and lo*lo do not overlap, so they join by concatenation
   always_comb begin
      full_sq = {hh_ff, ll_ff} + (srs_pkg::SQ_W'(hl_ff) << (srs_pkg::LO_W + 1));
      scaled  = full_sq >> srs_pkg::FRAC_BITS;
      sq_in   = ((scaled >> srs_pkg::ACC_W) != '0) ? srs_pkg::ACC_MAX
                                                  : scaled[srs_pkg::ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= mag_in;
         hh_ff  <= mag_hi * mag_hi;
         hl_ff  <= mag_hi * mag_lo;
         ll_ff  <= mag_lo * mag_lo;
         sq_ff  <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

[rtl/srs_back.sv]
// back part: folds finished rows into min, max, totals and squared deviations
// depends on srs_pkg, srs_rsp_if, srs_square and sparse_row_statistics_defines.svh
`include "sparse_row_statistics_defines.svh"

module srs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [srs_pkg::CAVG_W-1:0]        count_avg,
   input  logic signed [srs_pkg::SUM_W-1:0]  sum_avg,
   input  logic [srs_pkg::ABS_W-1:0]         abs_avg,
   input  logic                              fifo_empty,
   input  srs_pkg::row_rec_type              pop_rec,
   output logic                              pop,
   srs_rsp_if.source                         rsp_bus
);

   logic                             adv;
   logic [srs_pkg::BACK_STAGES-1:0]  stage_valid_ff;
   srs_pkg::row_rec_type             stage_rec_ff [srs_pkg::BACK_STAGES];
   logic signed [srs_pkg::DEV_W-1:0] dev_cnt_ff, dev_sum_ff, dev_abs_ff;
   logic [srs_pkg::ACC_W-1:0]        sq_cnt, sq_sum, sq_abs;
   srs_pkg::row_rec_type             r;
   logic                             fold;
   logic                             load_out;

   // running statistics
   logic [srs_pkg::CNT_W-1:0]        count_low_ff, count_low_in, count_low_upd;
   logic [srs_pkg::CNT_W-1:0]        count_high_ff, count_high_in, count_high_upd;
   logic signed [srs_pkg::SUM_W-1:0] sum_low_ff, sum_low_in, sum_low_upd;
   logic signed [srs_pkg::SUM_W-1:0] sum_high_ff, sum_high_in, sum_high_upd;
   logic signed [srs_pkg::TOT_W-1:0] sum_accum_ff, sum_accum_in, sum_accum_upd;
   logic [srs_pkg::ABS_W-1:0]        abs_low_ff, abs_low_in, abs_low_upd;
   logic [srs_pkg::ABS_W-1:0]        abs_high_ff, abs_high_in, abs_high_upd;
   logic [srs_pkg::ACC_W-1:0]        abs_accum_ff, abs_accum_in, abs_accum_upd;
   logic [srs_pkg::ACC_W-1:0]        sq_cnt_acc_ff, sq_cnt_acc_in, sq_cnt_acc_upd;
   logic [srs_pkg::ACC_W-1:0]        sq_sum_acc_ff, sq_sum_acc_in, sq_sum_acc_upd;
   logic [srs_pkg::ACC_W-1:0]        sq_abs_acc_ff, sq_abs_acc_in, sq_abs_acc_upd;
   logic signed [srs_pkg::TOT_W:0]   tot_wide;

   // result register
   logic                             out_valid_ff, out_valid_in;
   logic [srs_pkg::NZ_W-1:0]         out_nz_ff;
   logic [srs_pkg::CNT_W-1:0]        out_cnt_min_ff, out_cnt_max_ff;
   logic signed [srs_pkg::SUM_W-1:0] out_sum_min_ff, out_sum_max_ff;
   logic signed [srs_pkg::TOT_W-1:0] out_sum_tot_ff;
   logic [srs_pkg::ABS_W-1:0]        out_abs_min_ff, out_abs_max_ff;
   logic [srs_pkg::ACC_W-1:0]        out_abs_tot_ff;
   logic [srs_pkg::ACC_W-1:0]        out_sq_cnt_ff, out_sq_sum_ff, out_sq_abs_ff;

   // saturating add of two non-negative 63-bit quantities
   function automatic logic [srs_pkg::ACC_W-1:0] add_sat(
      input logic [srs_pkg::ACC_W-1:0] a,
      input logic [srs_pkg::ACC_W-1:0] b
   );
      logic [srs_pkg::ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[srs_pkg::ACC_W] ? srs_pkg::ACC_MAX : s[srs_pkg::ACC_W-1:0];
   endfunction

   // whole pipeline holds while a result waits untaken
   assign adv = !out_valid_ff || rsp_bus.ready;
   assign pop = adv && !fifo_empty;

   // stage 1 deviations and row record shift
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (adv) begin
         stage_valid_ff <= {stage_valid_ff[srs_pkg::BACK_STAGES-2:0], !fifo_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_rec_ff[0] <= pop_rec;
         for (int i = 1; i < srs_pkg::BACK_STAGES; i++) begin
            stage_rec_ff[i] <= stage_rec_ff[i-1];
         end
         dev_cnt_ff <= $signed(srs_pkg::DEV_W'(pop_rec.cnt) << srs_pkg::FRAC_BITS)
                       - $signed(srs_pkg::DEV_W'(count_avg));
         dev_sum_ff <= srs_pkg::DEV_W'($signed(pop_rec.ssum)) - srs_pkg::DEV_W'(sum_avg);
         dev_abs_ff <= $signed(srs_pkg::DEV_W'(pop_rec.asum))
                       - $signed(srs_pkg::DEV_W'(abs_avg));
      end
   end

   // stages 2 to 4 square the deviations
   srs_square u_sq_cnt (.clock(clock), .enable(adv), .diff(dev_cnt_ff), .square(sq_cnt));
   srs_square u_sq_sum (.clock(clock), .enable(adv), .diff(dev_sum_ff), .square(sq_sum));
   srs_square u_sq_abs (.clock(clock), .enable(adv), .diff(dev_abs_ff), .square(sq_abs));

   // fold the row leaving stage 4 into the statistics
   always_comb begin
      r        = stage_rec_ff[srs_pkg::BACK_STAGES-1];
      fold     = stage_valid_ff[srs_pkg::BACK_STAGES-1] && adv;
      load_out = fold && r.mlast;

      count_low_upd  = (r.cnt < count_low_ff) ? r.cnt : count_low_ff;
      count_high_upd = (r.cnt > count_high_ff) ? r.cnt : count_high_ff;
      sum_low_upd    = ($signed(r.ssum) < sum_low_ff) ? $signed(r.ssum) : sum_low_ff;
      sum_high_upd   = ($signed(r.ssum) > sum_high_ff) ? $signed(r.ssum) : sum_high_ff;
      abs_low_upd    = (r.asum < abs_low_ff) ? r.asum : abs_low_ff;
      abs_high_upd   = (r.asum > abs_high_ff) ? r.asum : abs_high_ff;

      tot_wide = (srs_pkg::TOT_W+1)'(sum_accum_ff) + (srs_pkg::TOT_W+1)'($signed(r.ssum));
      if (tot_wide[srs_pkg::TOT_W] != tot_wide[srs_pkg::TOT_W-1]) begin
         sum_accum_upd = tot_wide[srs_pkg::TOT_W] ? srs_pkg::TOT_MIN : srs_pkg::TOT_MAX;
      end else begin
         sum_accum_upd = tot_wide[srs_pkg::TOT_W-1:0];
      end
      abs_accum_upd  = add_sat(abs_accum_ff, srs_pkg::ACC_W'(r.asum));
      sq_cnt_acc_upd = add_sat(sq_cnt_acc_ff, sq_cnt);
      sq_sum_acc_upd = add_sat(sq_sum_acc_ff, sq_sum);
      sq_abs_acc_upd = add_sat(sq_abs_acc_ff, sq_abs);
   end

   // next state: hold, update, or return to initial values at matrix end
   always_comb begin
      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      sum_low_in    = sum_low_ff;
      sum_high_in   = sum_high_ff;
      sum_accum_in  = sum_accum_ff;
      abs_low_in    = abs_low_ff;
      abs_high_in   = abs_high_ff;
      abs_accum_in  = abs_accum_ff;
      sq_cnt_acc_in = sq_cnt_acc_ff;
      sq_sum_acc_in = sq_sum_acc_ff;
      sq_abs_acc_in = sq_abs_acc_ff;
      if (load_out) begin
         count_low_in  = srs_pkg::CNT_LOW_INIT;
         count_high_in = '0;
         sum_low_in    = srs_pkg::SUM_MAX;
         sum_high_in   = srs_pkg::SUM_MIN;
         sum_accum_in  = '0;
         abs_low_in    = srs_pkg::ABS_MAX;
         abs_high_in   = '0;
         abs_accum_in  = '0;
         sq_cnt_acc_in = '0;
         sq_sum_acc_in = '0;
         sq_abs_acc_in = '0;
      end else if (fold) begin
         count_low_in  = count_low_upd;
         count_high_in = count_high_upd;
         sum_low_in    = sum_low_upd;
         sum_high_in   = sum_high_upd;
         sum_accum_in  = sum_accum_upd;
         abs_low_in    = abs_low_upd;
         abs_high_in   = abs_high_upd;
         abs_accum_in  = abs_accum_upd;
         sq_cnt_acc_in = sq_cnt_acc_upd;
         sq_sum_acc_in = sq_sum_acc_upd;
         sq_abs_acc_in = sq_abs_acc_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_low_ff  <= srs_pkg::CNT_LOW_INIT;
         count_high_ff <= '0;
         sum_low_ff    <= srs_pkg::SUM_MAX;
         sum_high_ff   <= srs_pkg::SUM_MIN;
         sum_accum_ff  <= '0;
         abs_low_ff    <= srs_pkg::ABS_MAX;
         abs_high_ff   <= '0;
         abs_accum_ff  <= '0;
         sq_cnt_acc_ff <= '0;
         sq_sum_acc_ff <= '0;
         sq_abs_acc_ff <= '0;
      end else begin
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
         sum_low_ff    <= sum_low_in;
         sum_high_ff   <= sum_high_in;
         sum_accum_ff  <= sum_accum_in;
         abs_low_ff    <= abs_low_in;
         abs_high_ff   <= abs_high_in;
         abs_accum_ff  <= abs_accum_in;
         sq_cnt_acc_ff <= sq_cnt_acc_in;
         sq_sum_acc_ff <= sq_sum_acc_in;
         sq_abs_acc_ff <= sq_abs_acc_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_nz_ff      <= r.nonzero;
         out_cnt_min_ff <= count_low_upd;
         out_cnt_max_ff <= count_high_upd;
         out_sum_min_ff <= sum_low_upd;
         out_sum_max_ff <= sum_high_upd;
         out_sum_tot_ff <= sum_accum_upd;
         out_abs_min_ff <= abs_low_upd;
         out_abs_max_ff <= abs_high_upd;
         out_abs_tot_ff <= abs_accum_upd;
         out_sq_cnt_ff  <= sq_cnt_acc_upd;
         out_sq_sum_ff  <= sq_sum_acc_upd;
         out_sq_abs_ff  <= sq_abs_acc_upd;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.nonzero_count = out_nz_ff;
   assign rsp_bus.count_min     = out_cnt_min_ff;
   assign rsp_bus.count_max     = out_cnt_max_ff;
   assign rsp_bus.sum_min       = out_sum_min_ff;
   assign rsp_bus.sum_max       = out_sum_max_ff;
   assign rsp_bus.sum_total     = out_sum_tot_ff;
   assign rsp_bus.abs_min       = out_abs_min_ff;
   assign rsp_bus.abs_max       = out_abs_max_ff;
   assign rsp_bus.abs_total     = out_abs_tot_ff;
   assign rsp_bus.count_sq_dev  = out_sq_cnt_ff;
   assign rsp_bus.sum_sq_dev    = out_sq_sum_ff;
   assign rsp_bus.abs_sq_dev    = out_sq_abs_ff;

   `SRS_ASSERT_NEXT(a_back_cleared_at_end, clock, reset, load_out,
      out_valid_ff && count_high_ff == '0 && sum_accum_ff == '0 && sq_sum_acc_ff == '0,
      "statistics not cleared or result not loaded at matrix end")

endmodule

[rtl/sparse_row_statistics.sv]
// top level of the sparse row statistics block: configuration registers and wiring
// depends on srs_pkg, srs_req_if, srs_rsp_if, srs_front, srs_fifo and srs_back
//
//   channel   direction  handshake            carries
//   req_bus   in         valid/ready          one matrix entry word with row and matrix ends
//   rsp_bus   out        valid/ready          one statistics word per matrix
//   csr_*     in         write enable only    threshold and the three averages
//
// one entry word is accepted every cycle while the row queue has room; the front adds it
// into the registered row sums. a row end passes through a four-entry row queue and the
// back pipeline (deviation, magnitude, partial products, square, fold) into the result
// register. rows may end every cycle while the queue has room. synchronous reset clears
// control state, statistics and configuration, not data registers; no clearing pass.
// an untaken result holds the back, and the front stalls only once the row queue fills.
module sparse_row_statistics (
   input  logic                            clock,
   input  logic                            reset,
   srs_req_if.sink                         req_bus,
   srs_rsp_if.source                       rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [srs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srs_pkg::CSR_W-1:0]       csr_wdata
);

   logic [srs_pkg::THR_W-1:0]        thr_ff;
   logic [srs_pkg::CAVG_W-1:0]       cavg_ff;
   logic signed [srs_pkg::SUM_W-1:0] savg_ff;
   logic [srs_pkg::ABS_W-1:0]        aavg_ff;
   logic                             push, pop, fifo_empty, fifo_full;
   srs_pkg::row_rec_type             push_rec, pop_rec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         cavg_ff <= '0;
         savg_ff <= '0;
         aavg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (srs_pkg::csr_index_type'(csr_index))
            srs_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata[srs_pkg::THR_W-1:0];
            srs_pkg::CSR_COUNT_AVG: cavg_ff <= csr_wdata[srs_pkg::CAVG_W-1:0];
            srs_pkg::CSR_SUM_AVG:   savg_ff <= csr_wdata[srs_pkg::SUM_W-1:0];
            srs_pkg::CSR_ABS_AVG:   aavg_ff <= csr_wdata[srs_pkg::ABS_W-1:0];
            default: ;
         endcase
      end
   end

   // front, row queue, back
   srs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .threshold (thr_ff),
      .fifo_full (fifo_full),
      .push      (push),
      .push_rec  (push_rec)
   );

   srs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   srs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .count_avg  (cavg_ff),
      .sum_avg    (savg_ff),
      .abs_avg    (aavg_ff),
      .fifo_empty (fifo_empty),
      .pop_rec    (pop_rec),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
